### hdl/hfbm_pkg.sv
// shared types, constants and the four-id sort for the hex face boundary matcher
package hfbm_pkg;

  localparam int CORNERS  = 8;
  localparam int FACES    = 6;
  localparam int IdW      = 24;
  localparam int CodeW    = 8;
  localparam int CellIdxW = 10;
  localparam int SlotW    = 3;
  localparam int CountW   = 13;
  localparam int CfgDataW = 11;

  localparam logic [CountW-1:0] COUNT_MAX = 13'd8191;

  typedef logic [IdW-1:0]   id_t;
  typedef id_t [3:0]        quad_t;
  typedef id_t [CORNERS-1:0] corners_t;
  typedef logic [CodeW-1:0] code_t;
  typedef code_t [FACES-1:0] codes_t;
  typedef quad_t [FACES-1:0] faces_t;
  typedef logic [2:0]       corner_idx_t;

  // corners of each face
  localparam corner_idx_t FACE_TABLE [FACES][4] = '{
    '{3'd0, 3'd2, 3'd4, 3'd6},
    '{3'd1, 3'd3, 3'd5, 3'd7},
    '{3'd0, 3'd1, 3'd4, 3'd5},
    '{3'd2, 3'd3, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd4, 3'd5, 3'd6, 3'd7}
  };

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic CFG_CELL_COUNT = 1'b0;
  localparam logic CFG_INNER_CODE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic                ok;
    logic [CellIdxW-1:0] cell_idx;
    logic [SlotW-1:0]    slot;
    id_t                 vid;
    quad_t               qid;
    code_t               code;
  } item_t;

  // five compare-exchange steps, three levels deep
  function automatic quad_t sort4(quad_t v);
    quad_t s;
    id_t   t;
    s = v;
    if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
    if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
    if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
    if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    return s;
  endfunction

endpackage

### hdl/hfbm_front.sv
// front end: takes requests, checks ranges and sorts the query ids
module hfbm_front #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   req_type_i,
  input  logic [hfbm_pkg::CellIdxW-1:0] cell_index_i,
  input  logic [hfbm_pkg::SlotW-1:0]   slot_index_i,
  input  hfbm_pkg::id_t                vertex_id_i,
  input  hfbm_pkg::id_t                face_v0_i,
  input  hfbm_pkg::id_t                face_v1_i,
  input  hfbm_pkg::id_t                face_v2_i,
  input  hfbm_pkg::id_t                face_v3_i,
  input  logic signed [hfbm_pkg::CodeW-1:0] bnd_code_i,
  output logic                         push_o,
  output hfbm_pkg::item_t              item_o
);
  import hfbm_pkg::*;

  logic  in_range;
  quad_t raw;

  assign in_range = (32'(cell_index_i) < MAX_CELLS);
  assign push_o   = start_i && !busy_i;

  always_comb begin
    raw             = {face_v3_i, face_v2_i, face_v1_i, face_v0_i};
    item_o.cell_idx = cell_index_i;
    item_o.slot     = slot_index_i;
    item_o.vid      = vertex_id_i;
    item_o.code     = bnd_code_i;
    item_o.qid      = sort4(raw);
    item_o.op       = OP_NONE;
    item_o.ok       = 1'b0;
    case (req_type_i)
      REQ_LOAD: begin
        item_o.op = OP_LOAD;
        item_o.ok = in_range;
      end
      REQ_QUERY: begin
        item_o.op = OP_QUERY;
        item_o.ok = 1'b1;
      end
      REQ_READ: begin
        item_o.op = OP_READ;
        item_o.ok = in_range && (32'(slot_index_i) < FACES);
      end
      default: begin
        item_o.op = OP_NONE;
        item_o.ok = 1'b0;
      end
    endcase
  end

endmodule

### hdl/hfbm_queue.sv
// two-entry request queue between front and back end
module hfbm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hfbm_pkg::item_t item_i,
  input  logic            pop_i,
  output hfbm_pkg::item_t item_o,
  output logic            empty_o,
  output logic            full_o
);
  import hfbm_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = 1;

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hdl/hfbm_back.sv
// back end: corner and face code memories, scan pipeline and result register
module hfbm_back #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hfbm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          empty_i,
  input  hfbm_pkg::item_t               item_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [hfbm_pkg::CountW-1:0]   match_count_o,
  output logic                          found_o,
  output logic signed [hfbm_pkg::CodeW-1:0] code_read_o
);
  import hfbm_pkg::*;

  localparam int CellW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int LimW  = $clog2(MAX_CELLS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;

  // memories
  corners_t corner_mem [MAX_CELLS];
  codes_t   face_mem [MAX_CELLS];
  corners_t corner_rd_q;
  codes_t   face_rd_q;

  logic             cw_en;
  logic [CellW-1:0] cw_addr, cr_addr, fw_addr, fr_addr;
  logic [SlotW-1:0] cw_slot;
  id_t              cw_data;
  logic [FACES-1:0] fw_en;
  codes_t           fw_data;

  // control and pipeline registers
  logic [LimW-1:0]     scan_q, scan_d, limit_q, limit_d;
  logic [CountW-1:0]   acc_q, acc_d;
  quad_t               qid_q, qid_d;
  code_t               qcode_q, qcode_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                ok_q, ok_d;
  logic                s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [CellW-1:0]    s1_addr_q, s1_addr_d, s2_addr_q, s2_addr_d;
  faces_t              sorted_q, sorted_d;
  logic                done_q, done_d, found_q, found_d;
  logic [CountW-1:0]   count_q, count_d;
  code_t               code_q, code_d;
  logic [CfgDataW-1:0] cell_count_q, cell_count_d;
  code_t               inner_q, inner_d;

  logic [FACES-1:0] match;
  logic [2:0]       hits;
  logic [CountW:0]  sum;
  logic             scan_more;
  quad_t            tmp;

  assign scan_more = (scan_q < limit_q);

  // sort every face of the row that came out of the corner memory
  always_comb begin
    tmp = '0;
    for (int f = 0; f < FACES; f++) begin
      for (int k = 0; k < 4; k++) begin
        tmp[k] = corner_rd_q[FACE_TABLE[f][k]];
      end
      sorted_d[f] = sort4(tmp);
    end
  end

  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      match[f] = s2_v_q && (sorted_q[f] == qid_q);
    end
    hits = 3'($countones(match));
    sum  = {1'b0, acc_q} + (CountW+1)'(hits);
  end

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    limit_d      = limit_q;
    acc_d        = acc_q;
    qid_d        = qid_q;
    qcode_d      = qcode_q;
    slot_d       = slot_q;
    ok_d         = ok_q;
    s1_v_d       = 1'b0;
    s1_addr_d    = scan_q[CellW-1:0];
    s2_v_d       = s1_v_q;
    s2_addr_d    = s1_addr_q;
    done_d       = 1'b0;
    count_d      = count_q;
    found_d      = found_q;
    code_d       = code_q;
    cell_count_d = cell_count_q;
    inner_d      = inner_q;
    pop_o        = 1'b0;
    cw_en        = 1'b0;
    cw_addr      = CellW'(item_i.cell_idx);
    cw_slot      = item_i.slot;
    cw_data      = item_i.vid;
    cr_addr      = scan_q[CellW-1:0];
    fw_en        = '0;
    fw_addr      = CellW'(item_i.cell_idx);
    fw_data      = {FACES{inner_q}};
    fr_addr      = CellW'(item_i.cell_idx);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_COUNT: cell_count_d = cfg_data_i;
        CFG_INNER_CODE: inner_d = cfg_data_i[CodeW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (item_i.op)
            OP_LOAD: begin
              cw_en = item_i.ok;
              // corner 0 starts a cell: all faces go back to the inner code
              if (item_i.ok && (item_i.slot == '0)) begin
                fw_en = '1;
              end
              done_d  = 1'b1;
              count_d = '0;
              found_d = 1'b0;
              code_d  = '0;
            end
            OP_QUERY: begin
              limit_d = (32'(cell_count_q) > MAX_CELLS) ? LimW'(MAX_CELLS)
                                                         : LimW'(cell_count_q);
              scan_d  = '0;
              acc_d   = '0;
              qid_d   = item_i.qid;
              qcode_d = item_i.code;
              state_d = ST_SCAN;
            end
            OP_READ: begin
              slot_d  = item_i.slot;
              ok_d    = item_i.ok;
              state_d = ST_READ;
            end
            default: begin
              done_d  = 1'b1;
              count_d = '0;
              found_d = 1'b0;
              code_d  = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        count_d = '0;
        found_d = 1'b0;
        code_d  = ok_q ? face_rd_q[slot_q] : '0;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_more) begin
          s1_v_d = 1'b1;
          scan_d = scan_q + LimW'(1);
        end
        fw_en   = match;
        fw_addr = s2_addr_q;
        fw_data = {FACES{qcode_q}};
        acc_d   = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CountW-1:0];
        // all rows issued and the pipeline has drained
        if (!scan_more && !s1_v_q && !s2_v_q) begin
          done_d  = 1'b1;
          count_d = acc_q;
          found_d = (acc_q != '0);
          code_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      limit_q      <= '0;
      acc_q        <= '0;
      qid_q        <= '0;
      qcode_q      <= '0;
      slot_q       <= '0;
      ok_q         <= 1'b0;
      s1_v_q       <= 1'b0;
      s1_addr_q    <= '0;
      s2_v_q       <= 1'b0;
      s2_addr_q    <= '0;
      sorted_q     <= '0;
      done_q       <= 1'b0;
      count_q      <= '0;
      found_q      <= 1'b0;
      code_q       <= '0;
      cell_count_q <= '0;
      inner_q      <= '0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      limit_q      <= limit_d;
      acc_q        <= acc_d;
      qid_q        <= qid_d;
      qcode_q      <= qcode_d;
      slot_q       <= slot_d;
      ok_q         <= ok_d;
      s1_v_q       <= s1_v_d;
      s1_addr_q    <= s1_addr_d;
      s2_v_q       <= s2_v_d;
      s2_addr_q    <= s2_addr_d;
      sorted_q     <= sorted_d;
      done_q       <= done_d;
      count_q      <= count_d;
      found_q      <= found_d;
      code_q       <= code_d;
      cell_count_q <= cell_count_d;
      inner_q      <= inner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      corner_mem[cw_addr][cw_slot] <= cw_data;
    end
    corner_rd_q <= corner_mem[cr_addr];
  end

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < FACES; f++) begin
      if (fw_en[f]) begin
        face_mem[fw_addr][f] <= fw_data[f];
      end
    end
    face_rd_q <= face_mem[fr_addr];
  end

  assign done_o        = done_q;
  assign match_count_o = count_q;
  assign found_o       = found_q;
  assign code_read_o   = code_q;

endmodule

### hdl/hex_face_boundary_matcher.sv
// top level of the hex face boundary matcher
//
// channel   | direction | transfer condition   | payload
// ----------+-----------+----------------------+------------------------------------------
// request   | in        | start_i && !busy_o   | req_type, cell/slot index, vertex, face ids, code
// result    | out       | done_o (one cycle)   | match_count, found, code_read
// config    | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// a query scans the first min(cell_count, MAX_CELLS) cells of the table, and for it
// the corner memory delivers one cell row per cycle to the sort.
// a two-entry queue takes new requests while the back end works; busy_o means it is full.
// the receiver cannot stall: done_o marks each result for exactly one cycle.
// rst_ni clears control state only; memory contents are undefined until written.
module hex_face_boundary_matcher #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    req_type_i,
  input  logic [hfbm_pkg::CellIdxW-1:0] cell_index_i,
  input  logic [hfbm_pkg::SlotW-1:0]    slot_index_i,
  input  hfbm_pkg::id_t                 vertex_id_i,
  input  hfbm_pkg::id_t                 face_v0_i,
  input  hfbm_pkg::id_t                 face_v1_i,
  input  hfbm_pkg::id_t                 face_v2_i,
  input  hfbm_pkg::id_t                 face_v3_i,
  input  logic signed [hfbm_pkg::CodeW-1:0] bnd_code_i,
  output logic                          done_o,
  output logic [hfbm_pkg::CountW-1:0]   match_count_o,
  output logic                          found_o,
  output logic signed [hfbm_pkg::CodeW-1:0] code_read_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hfbm_pkg::CfgDataW-1:0] cfg_data_i
);
  import hfbm_pkg::*;

  item_t push_item, head_item;
  logic  push, pop, empty, full;

  assign busy_o = full;

  hfbm_front #(
    .MAX_CELLS(MAX_CELLS)
  ) u_front (
    .start_i      (start_i),
    .busy_i       (full),
    .req_type_i   (req_type_i),
    .cell_index_i (cell_index_i),
    .slot_index_i (slot_index_i),
    .vertex_id_i  (vertex_id_i),
    .face_v0_i    (face_v0_i),
    .face_v1_i    (face_v1_i),
    .face_v2_i    (face_v2_i),
    .face_v3_i    (face_v3_i),
    .bnd_code_i   (bnd_code_i),
    .push_o       (push),
    .item_o       (push_item)
  );

  hfbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty),
    .full_o  (full)
  );

  hfbm_back #(
    .MAX_CELLS(MAX_CELLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .empty_i       (empty),
    .item_i        (head_item),
    .pop_o         (pop),
    .done_o        (done_o),
    .match_count_o (match_count_o),
    .found_o       (found_o),
    .code_read_o   (code_read_o)
  );

endmodule

### hdl/hfbm_checker.sv
// port-level checks for the hex face boundary matcher and their bind
module hfbm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [hfbm_pkg::CountW-1:0] match_count_o,
  input logic                        found_o
);

  logic [2:0] pend_q, pend_d;
  logic       acc;

  assign acc = start_i && !busy_o;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q + {2'b00, acc} - {2'b00, done_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_orphan_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pend_q != 3'd0))
    else $error("result without an outstanding request");

  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more requests in flight than the queue and back end hold");

  a_busy_means_backlog : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (pend_q >= 3'd2))
    else $error("busy while fewer than two requests are pending");

  a_found_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (found_o == (match_count_o != '0)))
    else $error("found flag disagrees with match count");

endmodule

bind hex_face_boundary_matcher hfbm_checker u_checker (.*);

### tb/sv/hex_face_boundary_matcher_test.sv
// self-checking testbench for the hex face boundary matcher: directed table, then random phases
`timescale 1ns / 1ps

module hex_face_boundary_matcher_test;
  import hfbm_pkg::*;

  localparam int          CELLS         = 1024;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_PHASES = 10;
  localparam int          PHASE_ITEMS   = 38;
  localparam int          DRAIN_CYCLES  = 8;

  // the one request code the block leaves unused
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              hit;
    code_t             code;
  } outcome_t;

  typedef struct packed {
    logic [1:0]          req;
    logic [CellIdxW-1:0] cell_idx;
    logic [SlotW-1:0]    slot;
    id_t                 vid;
    quad_t               ids;
    code_t               code;
  } request_t;

  typedef enum logic {ROW_XFER, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  typed;
    outcome_t              want;
    request_t              item;
    logic                  cfg_idx;
    logic [CfgDataW-1:0]   cfg_val;
  } plan_row_t;

  localparam outcome_t NOTHING        = '0;
  localparam outcome_t READ_INNER_MIN = '{count: 13'd0, hit: 1'b0, code: 8'h80};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [1:0]                 req_type_i;
  logic [CellIdxW-1:0]        cell_index_i;
  logic [SlotW-1:0]           slot_index_i;
  id_t                        vertex_id_i;
  id_t                        face_v0_i;
  id_t                        face_v1_i;
  id_t                        face_v2_i;
  id_t                        face_v3_i;
  logic signed [CodeW-1:0]    bnd_code_i;
  logic                       done_o;
  logic [CountW-1:0]          match_count_o;
  logic                       found_o;
  logic signed [CodeW-1:0]    code_read_o;
  logic                       cfg_we_i;
  logic                       cfg_idx_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  hex_face_boundary_matcher #(
    .MAX_CELLS(CELLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .cell_index_i (cell_index_i),
    .slot_index_i (slot_index_i),
    .vertex_id_i  (vertex_id_i),
    .face_v0_i    (face_v0_i),
    .face_v1_i    (face_v1_i),
    .face_v2_i    (face_v2_i),
    .face_v3_i    (face_v3_i),
    .bnd_code_i   (bnd_code_i),
    .done_o       (done_o),
    .match_count_o(match_count_o),
    .found_o      (found_o),
    .code_read_o  (code_read_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // mirror of the cell table and the two registers
  id_t                corner_mem [CELLS][CORNERS];
  logic [CORNERS-1:0] corner_set [CELLS];
  code_t              face_code  [CELLS][FACES];
  logic [CfgDataW-1:0] scan_cells;
  code_t              inner_code_q;

  outcome_t    due_outcomes [$];
  int unsigned fail_cnt;
  int unsigned checked_cnt;
  int unsigned kind_cnt [4];
  int unsigned hit_queries;
  int unsigned match_total;
  int unsigned writes_cnt;
  int unsigned cycle_cnt;
  logic        calm;

  plan_row_t directed_plan [24];

  function automatic quad_t order_ids(quad_t v);
    id_t t;
    for (int i = 1; i < 4; i++) begin
      for (int j = i; j > 0; j--) begin
        if (v[j-1] > v[j]) begin
          t = v[j]; v[j] = v[j-1]; v[j-1] = t;
        end
      end
    end
    return v;
  endfunction

  // updates the mirror for one accepted transfer and returns its outcome
  function automatic outcome_t request_outcome(request_t r);
    outcome_t    o;
    quad_t       want_ids;
    quad_t       face_ids;
    int unsigned span;
    int unsigned hits;
    o = '0;
    kind_cnt[r.req]++;
    case (r.req)
      REQ_LOAD: begin
        corner_mem[r.cell_idx][r.slot] = r.vid;
        corner_set[r.cell_idx][r.slot] = 1'b1;
        if (r.slot == 0) begin
          for (int f = 0; f < FACES; f++) face_code[r.cell_idx][f] = inner_code_q;
        end
      end
      REQ_QUERY: begin
        span = (scan_cells > CELLS) ? CELLS : scan_cells;
        want_ids = order_ids(r.ids);
        hits = 0;
        for (int c = 0; c < span; c++) begin
          for (int f = 0; f < FACES; f++) begin
            for (int k = 0; k < 4; k++) face_ids[k] = corner_mem[c][FACE_TABLE[f][k]];
            if (order_ids(face_ids) == want_ids) begin
              face_code[c][f] = r.code;
              hits++;
            end
          end
        end
        o.count = (hits > COUNT_MAX) ? COUNT_MAX : CountW'(hits);
        o.hit = (hits != 0);
        match_total += hits;
        if (hits != 0) hit_queries++;
      end
      REQ_READ: begin
        if (r.slot < FACES) o.code = face_code[r.cell_idx][r.slot];
      end
      default: ;
    endcase
    return o;
  endfunction

  // mostly a handful of small ids so that faces of different cells coincide
  function automatic id_t pick_vertex();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return id_t'($urandom_range(0, 7));
    if (r < 8) return id_t'($urandom_range(0, 255));
    return id_t'($urandom);
  endfunction

  function automatic request_t random_item(int unsigned span);
    request_t    r;
    int unsigned pick;
    int unsigned c;
    int unsigned f;
    int unsigned j;
    id_t         t;
    r.req      = REQ_SPARE;
    r.cell_idx = CellIdxW'($urandom);
    r.slot     = SlotW'($urandom);
    r.vid      = id_t'($urandom);
    r.code     = code_t'($urandom);
    for (int k = 0; k < 4; k++) r.ids[k] = id_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.req = REQ_LOAD;
      if (span != 0 && $urandom_range(0, 9) < 7)
        r.cell_idx = CellIdxW'($urandom_range(0, span - 1));
      r.vid = pick_vertex();
    end else if (pick < 62) begin
      r.req = REQ_QUERY;
      if (span != 0 && $urandom_range(0, 3) != 0) begin
        // a face that exists, ids shuffled, now and then one id spoiled
        c = $urandom_range(0, span - 1);
        f = $urandom_range(0, FACES - 1);
        for (int k = 0; k < 4; k++) r.ids[k] = corner_mem[c][FACE_TABLE[f][k]];
        for (int k = 3; k > 0; k--) begin
          j = $urandom_range(0, k);
          t = r.ids[k]; r.ids[k] = r.ids[j]; r.ids[j] = t;
        end
        if ($urandom_range(0, 7) == 0) r.ids[$urandom_range(0, 3)] = pick_vertex();
      end else begin
        for (int k = 0; k < 4; k++) r.ids[k] = pick_vertex();
      end
    end else if (pick < 92) begin
      r.req = REQ_READ;
      r.slot = SlotW'($urandom_range(0, FACES - 1));
      if (span != 0 && $urandom_range(0, 9) < 7)
        r.cell_idx = CellIdxW'($urandom_range(0, span - 1));
      // faces of a cell never loaded stay out of reach
      if (!corner_set[r.cell_idx][0] || $urandom_range(0, 9) == 0)
        r.slot = SlotW'($urandom_range(FACES, 7));
    end
    return r;
  endfunction

  function automatic plan_row_t xfer(logic [1:0] req, logic [CellIdxW-1:0] cell_idx,
                                     logic [SlotW-1:0] slot, id_t vid, quad_t ids,
                                     code_t code);
    plan_row_t row;
    row = '0;
    row.kind = ROW_XFER;
    row.item = '{req: req, cell_idx: cell_idx, slot: slot, vid: vid, ids: ids, code: code};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, logic [CfgDataW-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic plan_row_t with_want(plan_row_t row, outcome_t want);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  task automatic issue(input request_t r, input logic typed, input outcome_t want);
    int unsigned gap;
    outcome_t    due;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= r.req;
    cell_index_i <= r.cell_idx;
    slot_index_i <= r.slot;
    vertex_id_i  <= r.vid;
    face_v0_i    <= r.ids[0];
    face_v1_i    <= r.ids[1];
    face_v2_i    <= r.ids[2];
    face_v3_i    <= r.ids[3];
    bnd_code_i   <= r.code;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    due = request_outcome(r);
    due_outcomes.push_back(typed ? want : due);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic idx, input logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_CELL_COUNT) scan_cells = value;
    else inner_code_q = value[CodeW-1:0];
    writes_cnt++;
    cfg_we_i <= 1'b0;
  endtask

  // every scanned cell must have all eight corners written before a query
  task automatic fill_cells(input int unsigned upto);
    request_t r;
    for (int c = 0; c < upto; c++) begin
      for (int k = 0; k < CORNERS; k++) begin
        if (!corner_set[c][k]) begin
          r = '0;
          r.req = REQ_LOAD;
          r.cell_idx = CellIdxW'(c);
          r.slot = SlotW'(k);
          r.vid = pick_vertex();
          issue(r, 1'b0, NOTHING);
        end
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // result checker: one transfer per done cycle, matched in order
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (due_outcomes.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result: count %0d found %b code %0d",
                 $time, match_count_o, found_o, code_read_o);
      end else begin
        want = due_outcomes.pop_front();
        checked_cnt++;
        if (match_count_o !== want.count) begin
          fail_cnt++;
          $display("%0t: match_count expected %0d actual %0d",
                   $time, want.count, match_count_o);
        end
        if (found_o !== want.hit) begin
          fail_cnt++;
          $display("%0t: found expected %b actual %b", $time, want.hit, found_o);
        end
        if (code_read_o !== want.code) begin
          fail_cnt++;
          $display("%0t: code_read expected %0d actual %0d",
                   $time, $signed(want.code), code_read_o);
        end
      end
    end
  end

  initial begin
    int unsigned span;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_type_i   = REQ_LOAD;
    cell_index_i = '0;
    slot_index_i = '0;
    vertex_id_i  = '0;
    face_v0_i    = '0;
    face_v1_i    = '0;
    face_v2_i    = '0;
    face_v3_i    = '0;
    bnd_code_i   = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_CELL_COUNT;
    cfg_data_i   = '0;
    calm         = 1'b0;
    scan_cells   = '0;
    inner_code_q = '0;
    for (int c = 0; c < CELLS; c++) begin
      corner_set[c] = '0;
      for (int k = 0; k < CORNERS; k++) corner_mem[c][k] = '0;
      for (int f = 0; f < FACES; f++) face_code[c][f] = '0;
    end

    // cell 0 corners: 0, max, 5, 5, 7, 8, 9, 10; face 4 holds the repeated id
    directed_plan = '{
      with_want(xfer(REQ_QUERY, 10'd0, 3'd0, 24'h0, '0, 8'h00), NOTHING),
      with_want(xfer(REQ_QUERY, 10'h3FF, 3'd7, 24'hFFFFFF, {4{24'hFFFFFF}}, 8'h7F), NOTHING),
      with_want(xfer(REQ_SPARE, 10'h3FF, 3'd7, 24'hFFFFFF, {4{24'hFFFFFF}}, 8'hFF), NOTHING),
      with_want(xfer(REQ_READ, 10'h3FF, 3'd6, 24'h0, '0, 8'h00), NOTHING),
      with_want(xfer(REQ_READ, 10'd0, 3'd7, 24'h0, '0, 8'h00), NOTHING),
      cfg_row(CFG_INNER_CODE, 11'h080),
      xfer(REQ_LOAD, 10'd0, 3'd0, 24'h000000, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd1, 24'hFFFFFF, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd2, 24'd5, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd3, 24'd5, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd4, 24'd7, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd5, 24'd8, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd6, 24'd9, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd7, 24'd10, '0, 8'h00),
      with_want(xfer(REQ_READ, 10'd0, 3'd0, 24'h0, '0, 8'h00), READ_INNER_MIN),
      cfg_row(CFG_CELL_COUNT, 11'd1),
      xfer(REQ_QUERY, 10'd0, 3'd0, 24'h0, {24'd5, 24'hFFFFFF, 24'd0, 24'd5}, 8'h7F),
      xfer(REQ_QUERY, 10'd0, 3'd0, 24'h0, {24'd0, 24'hFFFFFF, 24'd5, 24'd0}, 8'h11),
      xfer(REQ_READ, 10'd0, 3'd4, 24'h0, '0, 8'h00),
      xfer(REQ_QUERY, 10'd0, 3'd0, 24'h0, {24'd8, 24'd7, 24'hFFFFFF, 24'd0}, 8'hFF),
      xfer(REQ_READ, 10'd0, 3'd2, 24'h0, '0, 8'h00),
      xfer(REQ_LOAD, 10'd0, 3'd0, 24'h000000, '0, 8'h00),
      with_want(xfer(REQ_READ, 10'd0, 3'd4, 24'h0, '0, 8'h00), READ_INNER_MIN),
      with_want(xfer(REQ_READ, 10'd0, 3'd5, 24'h0, '0, 8'h00), READ_INNER_MIN)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG)
        write_setting(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
      else
        issue(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
    end

    // small tables, queries mostly taken from faces that exist
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) write_setting(CFG_INNER_CODE, 11'h07F);
      else if (p == 1) write_setting(CFG_INNER_CODE, 11'h000);
      else write_setting(CFG_INNER_CODE, CfgDataW'($urandom_range(0, 255)));
      span = (p == 0) ? 2 : $urandom_range(1, 24);
      write_setting(CFG_CELL_COUNT, CfgDataW'(span));
      calm = ($urandom_range(0, 2) == 0);
      fill_cells(span);
      repeat (PHASE_ITEMS) issue(random_item(span), 1'b0, NOTHING);
    end

    // nothing left to scan
    calm = 1'b0;
    write_setting(CFG_CELL_COUNT, 11'd0);
    repeat (10) issue(random_item(0), 1'b0, NOTHING);

    start_i <= 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d loads, %0d queries (%0d with matches, %0d faces hit), %0d reads",
             kind_cnt[REQ_LOAD], kind_cnt[REQ_QUERY], hit_queries, match_total,
             kind_cnt[REQ_READ]);
    $display("%0d spare requests, %0d register writes, %0d results checked in %0d cycles",
             kind_cnt[REQ_SPARE], writes_cnt, checked_cnt, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### hex_face_boundary_matcher.f
hdl/hfbm_pkg.sv
hdl/hfbm_front.sv
hdl/hfbm_queue.sv
hdl/hfbm_back.sv
hdl/hex_face_boundary_matcher.sv
hdl/hfbm_checker.sv
tb/sv/hex_face_boundary_matcher_test.sv
